@@ src/ssd_pkg.sv @@
// ============================================================================
// ssd_pkg: shared types and constants for the standard deviation block
// Holds the transaction payload structs, the sequencer states, status codes
// and the widths that the store, divider and root units agree on.
// ============================================================================
package ssd_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = 32 + ADDR_W;
    localparam int ACC_W       = 65 + ADDR_W;
    localparam int ROOT_W      = 34;
    localparam int SQ_IN_W     = 2 * ROOT_W;
    localparam int FRAC_SHIFT  = 14;
    localparam int DIV_NW      = ACC_W;
    localparam int DIV_DW      = ROOT_W + FRAC_SHIFT;

    localparam logic [31:0] SQRT12_Q30 = 32'd3719550787;

    // Division by twelve of a value below 2^32 as a reciprocal multiply:
    // floor(x / 12) = (x * DIV12_MAGIC) >> DIV12_SHIFT.
    localparam logic [31:0] DIV12_MAGIC = 32'hAAAAAAAB;
    localparam int          DIV12_SHIFT = 35;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_FLAT = 2'd2;
    localparam logic [1:0] STAT_DROP = 2'd3;

    typedef struct packed {
        logic signed [31:0] return_sample;
        logic               last_sample;
    } ssd_in_t;

    typedef struct packed {
        logic [31:0]        std_deviation;
        logic signed [31:0] sharpe_value;
        logic [10:0]        sample_total;
        logic [1:0]         status;
    } ssd_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ssd_unit_stat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN,
        ST_RFDIV,
        ST_SQSUM,
        ST_VAR,
        ST_ROOT,
        ST_SHMUL,
        ST_SHDIV,
        ST_OUT
    } ssd_state_t;

endpackage

@@ src/sample_stddev_sharpe_top.sv @@
// ============================================================================
// sample_stddev_sharpe_top: sample standard deviation and Sharpe ratio
// Stores a set of Q8.24 returns, then gives the sample deviation and the
// annualised Sharpe ratio of the set as one result transaction.
// ============================================================================
// Samples are taken one per cycle while the block is loading; each is written
// to a 1024-entry memory and added to a running sum. A sample marked last
// closes the set and starts the calculation, during which no input is taken:
// a division for the mean, a division of the risk-free rate by twelve with a
// reciprocal multiply, a second pass over the memory (n reads and then the
// drain of its pipeline), a division for the variance, a square root and, if
// the deviation is not zero, one multiply and a final division for the
// Sharpe ratio. The divisions by a sample count or by the deviation share
// one bit-serial divider. Sets with fewer than two samples finish at once.
// Results wait in an output register, so the next set may load while a
// result is still pending. Samples beyond capacity are dropped and flagged
// in status.
// ============================================================================
module sample_stddev_sharpe_top
    import ssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  ssd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ssd_out_t    out_data
);

    // Sequencer and set state.
    ssd_state_t              state_reg, state_next;
    logic                    launched_reg;
    logic [31:0]             rf_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;

    // Calculation registers.
    logic [31:0]        mean_reg;
    logic [31:0]        rf12_reg;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic [32:0]        mag_reg;
    logic [65:0]        prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ROOT_W-1:0]  dev_reg;
    logic [31:0]        sharpe_reg;
    logic               out_valid_reg;
    ssd_out_t           out_data_reg;

    // Combinational helpers.
    logic               in_fire;
    logic               store_ok;
    logic [CNT_W-1:0]   cnt_after;
    logic               issue;
    logic               pass_done;
    logic               out_free;
    logic               div_start;
    logic               sqrt_start;
    logic [DIV_NW-1:0]  div_dividend;
    logic [DIV_DW-1:0]  div_divisor;
    logic [DIV_NW-1:0]  div_quo;
    ssd_unit_stat_t     div_stat;
    logic [ROOT_W-1:0]  sqrt_root;
    ssd_unit_stat_t     sqrt_stat;
    logic [31:0]        rd_data;
    logic [SUM_W-1:0]   sum_mag;
    logic [31:0]        rf_mag;
    logic [65-DIV12_SHIFT:0] rf_q;
    logic [32:0]        q33;
    logic [32:0]        d_val;
    logic [32:0]        e_val;
    logic [32:0]        e_mag;
    logic [32:0]        mul_a, mul_b;
    logic [65:0]        mul_p;
    logic [31:0]        sharpe_sat;
    logic [1:0]         status_val;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid & in_ready;
    assign store_ok  = (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign cnt_after = store_ok ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // The second pass issues one read per cycle and then drains its pipeline.
    assign issue     = (state_reg == ST_SQSUM) && (rd_cnt_reg < cnt_reg);
    assign pass_done = (state_reg == ST_SQSUM) && !issue && !v1_reg && !v2_reg && !v3_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && in_data.last_sample)
                begin
                    state_next = (cnt_after < CNT_W'(2)) ? ST_OUT : ST_MEAN;
                end
            end
            ST_MEAN:  if (div_stat.done) state_next = ST_RFDIV;
            ST_RFDIV: state_next = ST_SQSUM;
            ST_SQSUM: if (pass_done) state_next = ST_VAR;
            ST_VAR:   if (div_stat.done) state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = (sqrt_root == '0) ? ST_OUT : ST_SHMUL;
                end
            end
            ST_SHMUL: state_next = ST_SHDIV;
            ST_SHDIV: if (div_stat.done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    // Operand selection for the shared divider and multiplier.
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rf_mag  = rf_reg[31] ? (32'd0 - rf_reg) : rf_reg;
    assign e_val   = {mean_reg[31], mean_reg} - {rf12_reg[31], rf12_reg};
    assign e_mag   = e_val[32] ? (33'd0 - e_val) : e_val;

    always_comb
    begin
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_a        = mag_reg;
        mul_b        = mag_reg;
        unique case (state_reg)
            ST_MEAN:
            begin
                div_start    = !launched_reg;
                div_dividend = DIV_NW'(sum_mag);
                div_divisor  = DIV_DW'(cnt_reg);
            end
            ST_RFDIV:
            begin
                mul_a = {1'b0, rf_mag};
                mul_b = {1'b0, DIV12_MAGIC};
            end
            ST_VAR:
            begin
                div_start    = !launched_reg;
                div_dividend = acc_reg;
                div_divisor  = DIV_DW'(cnt_reg - CNT_W'(1));
            end
            ST_ROOT:
            begin
                sqrt_start = !launched_reg;
            end
            ST_SHMUL:
            begin
                mul_a = e_mag;
                mul_b = {1'b0, SQRT12_Q30};
            end
            ST_SHDIV:
            begin
                div_start    = !launched_reg;
                div_dividend = DIV_NW'(prod_reg);
                div_divisor  = {dev_reg, {FRAC_SHIFT{1'b0}}};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign mul_p = {33'd0, mul_a} * {33'd0, mul_b};
    assign rf_q  = mul_p[65:DIV12_SHIFT];
    assign q33   = div_quo[32:0];
    assign d_val = {rd_data[31], rd_data} - {mean_reg[31], mean_reg};

    // Sharpe saturation: the negative side reaches one step further.
    always_comb
    begin
        if (e_val[32])
        begin
            sharpe_sat = (div_quo > DIV_NW'(33'h080000000)) ? 32'h80000000
                                                             : 32'd0 - div_quo[31:0];
        end
        else
        begin
            sharpe_sat = (div_quo > DIV_NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_quo[31:0];
        end
    end

    // Too few samples outranks dropped samples, which outrank a flat set.
    always_comb
    begin
        priority if (cnt_reg < CNT_W'(2))
        begin
            status_val = STAT_FEW;
        end
        else if (ovf_reg)
        begin
            status_val = STAT_DROP;
        end
        else if (dev_reg == '0)
        begin
            status_val = STAT_FLAT;
        end
        else
        begin
            status_val = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            launched_reg  <= 1'b0;
            rf_reg        <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                launched_reg <= 1'b0;
            end
            else
            begin
                launched_reg <= launched_reg | div_start | sqrt_start;
            end

            if (cfg_valid && cfg_ready)
            begin
                rf_reg <= cfg_data;
            end

            if (in_fire)
            begin
                if (store_ok)
                begin
                    sum_reg <= sum_reg + {{(SUM_W-32){in_data.return_sample[31]}},
                                          in_data.return_sample};
                    cnt_reg <= cnt_after;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (in_data.last_sample)
                begin
                    rd_cnt_reg <= '0;
                end
            end

            if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= '0;
                cnt_reg       <= '0;
                ovf_reg       <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the calculation.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.last_sample)
        begin
            acc_reg    <= '0;
            dev_reg    <= '0;
            sharpe_reg <= '0;
        end
        if (state_reg == ST_MEAN && div_stat.done)
        begin
            mean_reg <= sum_reg[SUM_W-1] ? 32'(33'd0 - q33) : q33[31:0];
        end
        if (state_reg == ST_RFDIV)
        begin
            rf12_reg <= rf_reg[31] ? (32'd0 - {1'b0, rf_q}) : {1'b0, rf_q};
        end
        if (v1_reg)
        begin
            mag_reg <= d_val[32] ? (33'd0 - d_val) : d_val;
        end
        if (v2_reg || state_reg == ST_SHMUL)
        begin
            prod_reg <= mul_p;
        end
        if (v3_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ST_ROOT && sqrt_stat.done)
        begin
            dev_reg <= sqrt_root;
        end
        if (state_reg == ST_SHDIV && div_stat.done)
        begin
            sharpe_reg <= sharpe_sat;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg.std_deviation <= (dev_reg[ROOT_W-1:32] != '0) ? 32'hFFFFFFFF
                                                                         : dev_reg[31:0];
            out_data_reg.sharpe_value  <= sharpe_reg;
            out_data_reg.sample_total  <= 11'(cnt_reg);
            out_data_reg.status        <= status_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ssd_store u_store (
        .clk     (clk),
        .wr_en   (in_fire && store_ok),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (in_data.return_sample),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    ssd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    ssd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (div_quo[SQ_IN_W-1:0]),
        .root  (sqrt_root),
        .stat  (sqrt_stat)
    );

endmodule

@@ src/ssd_store.sv @@
// ============================================================================
// ssd_store: sample memory
// Single write port and single read port with a registered read.
// ============================================================================
module ssd_store
    import ssd_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [MAX_SAMPLES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/ssd_div.sv @@
// ============================================================================
// ssd_div: restoring unsigned divider
// Produces one quotient bit per cycle; the quotient holds until next start.
// ============================================================================
module ssd_div
    import ssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0] quotient,
    output ssd_unit_stat_t    stat
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] dq_reg, dq_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_sub;
    logic              take;

    assign rem_sh  = {rem_reg, dq_reg[DIV_NW-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign take    = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DIV_NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            dq_next  = {dq_reg[DIV_NW-2:0], take};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = dq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ src/ssd_sqrt.sv @@
// ============================================================================
// ssd_sqrt: digit-by-digit integer square root
// Retires one root bit per cycle and gives the exact floor root.
// ============================================================================
module ssd_sqrt
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SQ_IN_W-1:0] value,
    output logic [ROOT_W-1:0]  root,
    output ssd_unit_stat_t     stat
);

    localparam int CW = $clog2(ROOT_W + 1);

    logic [SQ_IN_W-1:0] val_reg, val_next;
    logic [ROOT_W:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ROOT_W+2:0]  rem_sh;
    logic [ROOT_W+2:0]  trial;
    logic               take;

    assign rem_sh = {rem_reg, val_reg[SQ_IN_W-1:SQ_IN_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[SQ_IN_W-3:0], 2'b00};
            rem_next  = take ? (ROOT_W+1)'(rem_sh - trial) : (ROOT_W+1)'(rem_sh);
            root_next = {root_reg[ROOT_W-2:0], take};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// testbench: self-checking bench for the standard deviation and Sharpe block
// Sends sets of return samples over the input channel, works out the expected
// deviation, Sharpe ratio, count and status of each set with a behavioural
// model, and compares every result transaction field by field.
// ============================================================================
module testbench;
    import ssd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 600;

    logic     clk;
    logic     rst_n;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     [31:0] cfg_data;
    logic     in_valid;
    logic     in_ready;
    ssd_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    ssd_out_t out_data;

    sample_stddev_sharpe_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The model's own copy of the register and of the state of the open set.
    logic signed [31:0] model_rf;
    logic signed [31:0] set_samples[$];
    logic               set_dropped;

    ssd_out_t expected_results[$];
    int       error_count;
    int       idle_cycles;
    bit       idle_enable;
    bit       hold_receiver;
    int       hold_length;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The exact integer floor square root of a value below 2^68.
    function automatic logic [33:0] floor_root(input logic [127:0] v);
        logic [33:0]  r;
        logic [33:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c  = r | (34'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= v)
                r = c;
        end
        return r;
    endfunction

    // Works out the result that the set just closed should produce.
    function automatic ssd_out_t stats_of_set();
        ssd_out_t           res;
        int                 n;
        logic signed [63:0] total;
        logic signed [63:0] mean;
        logic signed [63:0] diff;
        logic signed [63:0] excess;
        logic [63:0]        mag;
        logic [127:0]       sq_sum;
        logic [127:0]       quot;
        logic [33:0]        dev;
        n        = set_samples.size();
        total    = '0;
        sq_sum   = '0;
        dev      = '0;
        res      = '0;
        res.sample_total = 11'(n);
        if (n < 2)
        begin
            res.status = STAT_FEW;
            return res;
        end
        foreach (set_samples[i])
            total += 64'(set_samples[i]);
        mean = total / n;
        foreach (set_samples[i])
        begin
            diff   = 64'(set_samples[i]) - mean;
            mag    = diff < 0 ? 64'(-diff) : 64'(diff);
            sq_sum += 128'(mag) * 128'(mag);
        end
        dev = floor_root(sq_sum / 128'(n - 1));
        res.std_deviation = dev > 34'hFFFF_FFFF ? 32'hFFFF_FFFF : dev[31:0];
        if (dev != 0)
        begin
            excess = mean - 64'(model_rf) / 12;
            mag    = excess < 0 ? 64'(-excess) : 64'(excess);
            quot   = (128'(mag) * 128'(SQRT12_Q30)) / (128'(dev) << FRAC_SHIFT);
            if (excess < 0)
            begin
                if (quot > 128'h8000_0000)
                    quot = 128'h8000_0000;
                res.sharpe_value = -quot[31:0];
            end
            else
                res.sharpe_value = quot > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : quot[31:0];
        end
        if (set_dropped)
            res.status = STAT_DROP;
        else if (dev == 0)
            res.status = STAT_FLAT;
        else
            res.status = STAT_OK;
        return res;
    endfunction

    // Now and then the sender drops valid for a random number of cycles.
    task automatic idle_gap();
        if (idle_enable && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 27);
        end
    endtask

    // Sends one sample transaction and updates the model once it is taken.
    // Valid stays high afterwards; the next gap or the drain lowers it.
    task automatic send_sample(input logic signed [31:0] value, input bit last);
        idle_gap();
        in_valid              <= 1'b1;
        in_data.return_sample <= value;
        in_data.last_sample   <= last;
        do
            @(posedge clk);
        while (!in_ready);
        if (set_samples.size() < MAX_SAMPLES)
            set_samples.push_back(value);
        else
            set_dropped = 1'b1;
        if (last)
        begin
            expected_results.push_back(stats_of_set());
            set_samples.delete();
            set_dropped = 1'b0;
        end
    endtask

    // Draws a return: mostly modest values, sometimes anything at all.
    function automatic logic [31:0] random_return(input int spread);
        if ($urandom_range(9) == 0)
            return $urandom;
        return $urandom_range(2 * spread) - spread;
    endfunction

    task automatic send_set(input int count, input int spread);
        for (int i = 0; i < count; i++)
            send_sample(random_return(spread), i == count - 1);
    endtask

    // Waits until every result has come back and the block has gone quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_risk_free(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_rf = value;
    endtask

    // Extremes of the sample field and the short and flat special cases.
    task automatic test_directed();
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh0100_0000, 1'b0);
        send_sample(32'sh0100_0000, 1'b0);
        send_sample(32'sh0100_0000, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh0002_0000, 1'b0);
        send_sample(-32'sh0001_0000, 1'b0);
        send_sample(32'sh0000_0001, 1'b0);
        send_sample(32'sh0000_0000, 1'b1);
        send_sample(32'sh0000_0003, 1'b0);
        send_sample(32'sh0000_0004, 1'b1);
    endtask

    // Fills the store past its capacity, so the trailing samples and the
    // closing one are dropped.
    task automatic test_capacity();
        send_set(MAX_SAMPLES + 3, 32'h0080_0000);
    endtask

    // Long hold-off on the receiver while short sets keep arriving.
    task automatic test_backpressure();
        hold_length   = 3000;
        hold_receiver = 1'b1;
        for (int i = 0; i < 40; i++)
            send_set($urandom_range(1, 4), 32'h0100_0000);
    endtask

    task automatic test_random(input int sets);
        for (int s = 0; s < sets; s++)
        begin
            idle_enable = (s % 60) >= 20;
            send_set($urandom_range(1, 7), $urandom_range(1, 32'h0400_0000));
        end
        idle_enable = 1'b1;
    endtask

    // Receiver: random stalls plus the one long hold-off.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_ready <= 1'b0;
                repeat (hold_length) @(posedge clk);
                hold_receiver = 1'b0;
            end
            out_ready <= idle_enable ? ($urandom_range(99) >= 27) : 1'b1;
        end
    end

    // Compares each accepted result with the oldest expected one.
    initial
    begin
        ssd_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction");
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.std_deviation !== want.std_deviation)
                    begin
                        $error("std_deviation: expected %h, got %h",
                               want.std_deviation, out_data.std_deviation);
                        error_count++;
                    end
                    if (out_data.sharpe_value !== want.sharpe_value)
                    begin
                        $error("sharpe_value: expected %h, got %h",
                               want.sharpe_value, out_data.sharpe_value);
                        error_count++;
                    end
                    if (out_data.sample_total !== want.sample_total)
                    begin
                        $error("sample_total: expected %0d, got %0d",
                               want.sample_total, out_data.sample_total);
                        error_count++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, out_data.status);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run after a long spell with no transaction at all.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready) || hold_receiver)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        error_count   = 0;
        idle_enable   = 1'b1;
        hold_receiver = 1'b0;
        hold_length   = 0;
        model_rf      = '0;
        set_dropped   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_risk_free(32'h7FFF_FFFF);
        test_directed();
        write_risk_free(32'h8000_0000);
        test_random(30);
        test_capacity();
        write_risk_free(32'h0080_0000);
        test_backpressure();
        test_random(60);
        write_risk_free($urandom);
        test_random(60);
        write_risk_free(32'hFFFF_FFFF);
        test_random(30);

        wait_drained();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
